### hdl/fpns_pkg.sv
// ----------------------------------------------------------------------------
// fpns_pkg
// Shared widths, codes, reset constants and clipping limits of the noise-driven FIR unit.
// ----------------------------------------------------------------------------
package fpns_pkg;

   // Filter length and derived index widths
   localparam int TAPS  = 64;
   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W = TAP_W + 1;

   // Datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int INDEX_W  = 6;
   localparam int AMP_W    = 15;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + TAP_W + 1;
   localparam int FRAC_W   = 15;
   localparam int Q_W      = ACC_W - FRAC_W;

   // Stream payload widths (padded to whole bytes)
   localparam int REQ_DATA_W = ((INDEX_W + COEF_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

   // Reset values
   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(8000);
   localparam logic [15:0]      LFSR_SEED = 16'hFFFF;

   // Rounding and clipping limits
   localparam logic signed [ACC_W-1:0]    TRUNC_BIAS = ACC_W'((1 << FRAC_W) - 1);
   localparam logic signed [Q_W-1:0]      Q_MAX      = Q_W'(32767);
   localparam logic signed [Q_W-1:0]      Q_MIN      = Q_W'(-32768);
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 16'sh8000;

   // Command codes carried in tuser
   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

endpackage

### hdl/fir_filter_prbs_noise_source_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_prbs_noise_source_unit
// FIR filter fed by a 16-bit LFSR noise source, one MAC shared by all taps.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries commands. tuser = 0 is a sample tick: the LFSR
//   produces a +/- noise_amplitude sample, it enters the delay line and one
//   filtered result leaves on the rsp_ channel. tuser = 1 writes one Q15
//   coefficient and returns nothing.
//   csr_wr_en / csr_wr_data load noise_amplitude; the user must write it only while the block is idle (not enforced).
// Timing:
//   A coefficient write is taken in ST_IDLE, which stays ready for the next
//   command. On a tick the single multiply-accumulate unit walks the taps one
//   per cycle through the registered memory read, the product register and
//   the accumulator, then ST_DONE truncates and clips. req_tready is low
//   while a tick is being processed.
// Reset:
//   LFSR loads 0xFFFF, amplitude 8000, delay line and coefficients read as
//   zero (valid bits cleared at once, no sweep).
// Stall:
//   A result waits in the rsp_ output register; the next command is taken
//   meanwhile, and a following tick holds in its final cycle until the
//   register frees up.
// ----------------------------------------------------------------------------
module fir_filter_prbs_noise_source_unit (
   input  logic                             clock,
   input  logic                             reset,
   // command stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: [5:0] coef_index, [21:6] coef_value, [23:22] zero
   input  logic [fpns_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: [0] cmd
   input  logic                             req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: [15:0] filtered_sample
   output logic [fpns_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: [0] saturated
   output logic                             rsp_tuser,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [fpns_pkg::AMP_W-1:0]       csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Control state
   state_type                       state_ff, state_in;
   logic [fpns_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [fpns_pkg::TAP_W-1:0]      head_ff, head_in;
   logic [15:0]                     lfsr_ff, lfsr_in;
   logic [fpns_pkg::AMP_W-1:0]      amp_ff, amp_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            mul_vld_ff, mul_vld_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   logic [fpns_pkg::TAPS-1:0]       coef_ok_ff, coef_ok_in;
   logic [fpns_pkg::TAPS-1:0]       tap_ok_ff, tap_ok_in;

   // Datapath registers
   logic signed [fpns_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [fpns_pkg::PROD_W-1:0]   mul_ff;
   logic signed [fpns_pkg::COEF_W-1:0]   coef_rd_ff;
   logic signed [fpns_pkg::SAMPLE_W-1:0] tap_rd_ff;
   logic                                 coef_rv_ff;
   logic                                 tap_rv_ff;
   logic signed [fpns_pkg::SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                                 rsp_sat_ff, rsp_sat_in;

   // Memories
   logic signed [fpns_pkg::COEF_W-1:0]   coef_mem [fpns_pkg::TAPS];
   logic signed [fpns_pkg::SAMPLE_W-1:0] tap_mem  [fpns_pkg::TAPS];

   // Decoded request
   logic                                 req_acc;
   logic                                 tick_acc;
   logic                                 wr_acc;
   logic [fpns_pkg::INDEX_W-1:0]         req_index;
   logic signed [fpns_pkg::COEF_W-1:0]   req_value;
   logic                                 idx_in_range;
   logic [fpns_pkg::TAP_W-1:0]           wr_addr;

   // Noise and read addressing
   logic                                 lfsr_fb;
   logic signed [fpns_pkg::SAMPLE_W-1:0] amp_ext;
   logic signed [fpns_pkg::SAMPLE_W-1:0] noise;
   logic [fpns_pkg::CNT_W-1:0]           head_w;
   logic [fpns_pkg::CNT_W-1:0]           ring_w;
   logic [fpns_pkg::TAP_W-1:0]           coef_addr;
   logic [fpns_pkg::TAP_W-1:0]           ring_addr;

   // MAC operands and output formatting
   logic signed [fpns_pkg::COEF_W-1:0]   coef_op;
   logic signed [fpns_pkg::SAMPLE_W-1:0] tap_op;
   logic signed [fpns_pkg::ACC_W-1:0]    bias_acc;
   logic signed [fpns_pkg::Q_W-1:0]      q;
   logic                                 out_free;

   // Unpack the request transaction
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_acc      = req_tvalid && req_tready;
   assign tick_acc     = req_acc && (fpns_pkg::cmd_type'(req_tuser) == fpns_pkg::CMD_TICK);
   assign wr_acc       = req_acc && (fpns_pkg::cmd_type'(req_tuser) == fpns_pkg::CMD_WRITE);
   assign req_index    = req_tdata[fpns_pkg::INDEX_W-1:0];
   assign req_value    = req_tdata[fpns_pkg::INDEX_W +: fpns_pkg::COEF_W];
   assign idx_in_range = (32'(req_index) < fpns_pkg::TAPS);
   assign wr_addr      = fpns_pkg::TAP_W'(req_index);

   // Draw the noise sample from LFSR bit 0 before the shift
   assign lfsr_fb = lfsr_ff[0] ^ lfsr_ff[1] ^ lfsr_ff[11] ^ lfsr_ff[13];
   assign amp_ext = signed'({1'b0, amp_ff});
   assign noise   = lfsr_ff[0] ? -amp_ext : amp_ext;

   // Tap i lives at ring position head - i, wrapped into the delay line
   assign head_w    = {1'b0, head_ff};
   assign ring_w    = (head_w >= cnt_ff) ? (head_w - cnt_ff)
                                         : (head_w + fpns_pkg::CNT_W'(fpns_pkg::TAPS) - cnt_ff);
   assign ring_addr = ring_w[fpns_pkg::TAP_W-1:0];
   assign coef_addr = cnt_ff[fpns_pkg::TAP_W-1:0];

   // Unwritten entries read as zero
   assign coef_op = coef_rv_ff ? coef_rd_ff : '0;
   assign tap_op  = tap_rv_ff  ? tap_rd_ff  : '0;

   // Truncate toward zero after the Q15 shift
   assign bias_acc = acc_ff[fpns_pkg::ACC_W-1] ? (acc_ff + fpns_pkg::TRUNC_BIAS) : acc_ff;
   assign q        = fpns_pkg::Q_W'(bias_acc >>> fpns_pkg::FRAC_W);
   assign out_free = !rsp_vld_ff || rsp_tready;

   // Next-state and control logic
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      lfsr_in     = lfsr_ff;
      amp_in      = amp_ff;
      rd_vld_in   = 1'b0;
      mul_vld_in  = rd_vld_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      coef_ok_in  = coef_ok_ff;
      tap_ok_in   = tap_ok_ff;
      acc_in      = acc_ff;
      rsp_data_in = rsp_data_ff;
      rsp_sat_in  = rsp_sat_ff;

      if (csr_wr_en) begin
         amp_in = csr_wr_data;
      end

      // Accumulate the product that left the multiplier
      if (mul_vld_ff) begin
         acc_in = acc_ff + fpns_pkg::ACC_W'(mul_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (wr_acc && idx_in_range) begin
               coef_ok_in[wr_addr] = 1'b1;
            end
            if (tick_acc) begin
               lfsr_in            = {lfsr_ff[14:0], lfsr_fb};
               tap_ok_in[head_ff] = 1'b1;
               acc_in             = '0;
               cnt_in             = '0;
               state_in           = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            rd_vld_in = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == fpns_pkg::CNT_W'(fpns_pkg::TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               if (q > fpns_pkg::Q_MAX) begin
                  rsp_data_in = fpns_pkg::OUT_MAX;
                  rsp_sat_in  = 1'b1;
               end else if (q < fpns_pkg::Q_MIN) begin
                  rsp_data_in = fpns_pkg::OUT_MIN;
                  rsp_sat_in  = 1'b1;
               end else begin
                  rsp_data_in = q[fpns_pkg::SAMPLE_W-1:0];
                  rsp_sat_in  = 1'b0;
               end
               // Advance the delay line by moving its head
               head_in  = (head_ff == fpns_pkg::TAP_W'(fpns_pkg::TAPS - 1)) ? '0
                                                                           : head_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, control flags and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         head_ff    <= '0;
         lfsr_ff    <= fpns_pkg::LFSR_SEED;
         amp_ff     <= fpns_pkg::AMP_RESET;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         coef_ok_ff <= '0;
         tap_ok_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         head_ff    <= head_in;
         lfsr_ff    <= lfsr_in;
         amp_ff     <= amp_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         coef_ok_ff <= coef_ok_in;
         tap_ok_ff  <= tap_ok_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // Write and read the coefficient and delay-line memories
   always_ff @(posedge clock) begin
      if (wr_acc && idx_in_range) begin
         coef_mem[wr_addr] <= req_value;
      end
      if (tick_acc) begin
         tap_mem[head_ff] <= noise;
      end
      coef_rd_ff <= coef_mem[coef_addr];
      tap_rd_ff  <= tap_mem[ring_addr];
      coef_rv_ff <= coef_ok_ff[coef_addr];
      tap_rv_ff  <= tap_ok_ff[ring_addr];
   end

   // Register each product before it reaches the accumulator
   always_ff @(posedge clock) begin
      mul_ff <= coef_op * tap_op;
   end

   // Drive the result stream
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = fpns_pkg::RSP_DATA_W'(unsigned'(rsp_data_ff));
   assign rsp_tuser  = rsp_sat_ff;

endmodule

### sim/tb_fir_filter_prbs_noise_source_unit.sv
// ----------------------------------------------------------------------------
// tb_fir_filter_prbs_noise_source_unit
// Self-checking bench for the noise-driven FIR unit. Commands go in on the
// req_ stream with random gaps. A local filter model tracks the LFSR, the delay
// line, the coefficients and the amplitude, and queues one expected output per
// sample tick. Every rsp_ transaction is compared field by field with the
// oldest queued output, while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_fir_filter_prbs_noise_source_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // One filter output: sample and clip flag
   typedef struct packed {
      logic signed [fpns_pkg::SAMPLE_W-1:0] sample;
      logic                                 sat;
   } filt_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [fpns_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [fpns_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_wr_en = 1'b0;
   logic [fpns_pkg::AMP_W-1:0]      csr_wr_data = '0;

   // Filter model state
   logic [15:0]                          lfsr_state;
   logic [fpns_pkg::AMP_W-1:0]           noise_amp;
   logic signed [fpns_pkg::SAMPLE_W-1:0] delay_line [fpns_pkg::TAPS];
   logic signed [fpns_pkg::COEF_W-1:0]   coef_store [fpns_pkg::TAPS];
   filt_result_type                      filt_expect_q [$];

   // Bookkeeping
   bit idle_on = 1'b1;
   int hold_cnt = 0;
   int fail_count = 0;
   int tick_count = 0;
   int write_count = 0;
   int sat_count = 0;
   int result_count = 0;

   fir_filter_prbs_noise_source_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the noise source, run the dot product, shift the delay line
   function automatic filt_result_type run_filter_tick();
      logic            b0;
      logic            fb;
      int              amp;
      longint          acc;
      longint          q;
      filt_result_type r;
      b0 = lfsr_state[0];
      fb = lfsr_state[0] ^ lfsr_state[1] ^ lfsr_state[11] ^ lfsr_state[13];
      lfsr_state = {lfsr_state[14:0], fb};
      amp = int'(noise_amp);
      delay_line[0] = fpns_pkg::SAMPLE_W'(b0 ? -amp : amp);
      acc = 0;
      for (int i = 0; i < fpns_pkg::TAPS; i++) begin
         acc += longint'(coef_store[i]) * longint'(delay_line[i]);
      end
      for (int i = fpns_pkg::TAPS - 1; i > 0; i--) begin
         delay_line[i] = delay_line[i-1];
      end
      // Truncate toward zero, then clip to 16 bits
      q = (acc < 0) ? -((-acc) >> fpns_pkg::FRAC_W) : (acc >> fpns_pkg::FRAC_W);
      r.sat = 1'b0;
      if (q > 32767) begin
         q = 32767;
         r.sat = 1'b1;
      end else if (q < -32768) begin
         q = -32768;
         r.sat = 1'b1;
      end
      r.sample = fpns_pkg::SAMPLE_W'(q);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input int exp_v, input int act_v);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v,
                  act_v);
      end
   endtask

   // Compare one rsp_ transaction with the oldest expected output
   task automatic check_result();
      filt_result_type exp_r;
      result_count++;
      if (filt_expect_q.size() == 0) begin
         note_mismatch("unexpected result, sample", 0,
                       $signed(rsp_tdata[fpns_pkg::SAMPLE_W-1:0]));
      end else begin
         exp_r = filt_expect_q.pop_front();
         if (rsp_tdata[fpns_pkg::SAMPLE_W-1:0] !== exp_r.sample) begin
            note_mismatch("filtered_sample", exp_r.sample,
                          $signed(rsp_tdata[fpns_pkg::SAMPLE_W-1:0]));
         end
         if (rsp_tuser !== exp_r.sat) begin
            note_mismatch("saturated", exp_r.sat, rsp_tuser);
         end
      end
   endtask

   // Result side: check each transaction, then hold tready low at random while valid
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            hold_cnt = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (rsp_tvalid && hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_cnt == 0);
         end
      end
   end

   // Send one command after a random gap and update the model on acceptance
   task automatic send_cmd(input fpns_pkg::cmd_type cmd,
                           input logic [fpns_pkg::INDEX_W-1:0] idx,
                           input logic signed [fpns_pkg::COEF_W-1:0] val);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= fpns_pkg::REQ_DATA_W'({val, idx});
      do @(posedge clock); while (!req_tready);
      if (cmd == fpns_pkg::CMD_WRITE) begin
         if (int'(idx) < fpns_pkg::TAPS) coef_store[idx] = val;
         write_count++;
      end else begin
         filt_expect_q.push_back(run_filter_tick());
         if (filt_expect_q[$].sat) sat_count++;
         tick_count++;
      end
   endtask

   // Tick with random content in the fields it must ignore
   task automatic send_tick();
      send_cmd(fpns_pkg::CMD_TICK, fpns_pkg::INDEX_W'($urandom_range(0, 63)),
               fpns_pkg::COEF_W'($urandom_range(0, 65535)));
   endtask

   // Drop valid, drain all results, then let a full tick time pass
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (filt_expect_q.size() != 0) @(posedge clock);
      repeat (fpns_pkg::TAPS + 10) @(posedge clock);
   endtask

   task automatic set_amplitude(input logic [fpns_pkg::AMP_W-1:0] amp);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= amp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      noise_amp = amp;
   endtask

   // All coefficients zero after reset: output stays at zero
   task automatic test_zero_coefficients();
      repeat (3) send_tick();
   endtask

   // Coefficient and index extremes at the reset amplitude
   task automatic test_coefficient_extremes();
      send_cmd(fpns_pkg::CMD_WRITE, 6'd0, 16'sh7FFF);
      send_cmd(fpns_pkg::CMD_WRITE, 6'd63, 16'sh8000);
      send_cmd(fpns_pkg::CMD_WRITE, 6'd1, 16'sh8000);
      repeat (4) send_tick();
   endtask

   // Amplitude extremes: full scale drives the output into clipping
   task automatic test_amplitude_extremes();
      set_amplitude(fpns_pkg::AMP_W'(32767));
      send_cmd(fpns_pkg::CMD_WRITE, 6'd2, 16'sh8000);
      repeat (5) send_tick();
      set_amplitude(fpns_pkg::AMP_W'(0));
      repeat (3) send_tick();
   endtask

   // Random phases: new amplitude each phase, mixed writes and ticks
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [fpns_pkg::AMP_W-1:0]         amp;
      logic signed [fpns_pkg::COEF_W-1:0] val;
      for (int p = 0; p < phases; p++) begin
         case (p)
            0: amp = fpns_pkg::AMP_W'(32767);
            1: amp = fpns_pkg::AMP_W'(0);
            2: amp = fpns_pkg::AMP_W'(1);
            3: amp = fpns_pkg::AMP_RESET;
            default: amp = fpns_pkg::AMP_W'($urandom_range(0, 32767));
         endcase
         set_amplitude(amp);
         idle_on = (p % 4 != 3);
         for (int n = 0; n < per_phase; n++) begin
            if ($urandom_range(0, 9) < 3) begin
               case ($urandom_range(0, 7))
                  0: val = 16'sh7FFF;
                  1: val = 16'sh8000;
                  2: val = fpns_pkg::COEF_W'($urandom_range(0, 511)) - 16'sd256;
                  default: val = fpns_pkg::COEF_W'($urandom_range(0, 65535));
               endcase
               send_cmd(fpns_pkg::CMD_WRITE, fpns_pkg::INDEX_W'($urandom_range(0, 63)), val);
            end else begin
               send_tick();
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // Main sequence
   initial begin
      lfsr_state = fpns_pkg::LFSR_SEED;
      noise_amp  = fpns_pkg::AMP_RESET;
      for (int i = 0; i < fpns_pkg::TAPS; i++) begin
         delay_line[i] = '0;
         coef_store[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_coefficients();
      test_coefficient_extremes();
      test_amplitude_extremes();
      test_random_traffic(10, 48);

      wait_drained();
      $display("Sent %0d sample ticks and %0d coefficient writes", tick_count, write_count);
      $display("Checked %0d outputs, %0d of them clipped", result_count, sat_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #4ms;
      $display("Timeout with %0d outputs still pending", filt_expect_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
hdl/fpns_pkg.sv
hdl/fir_filter_prbs_noise_source_unit.sv
sim/tb_fir_filter_prbs_noise_source_unit.sv
